### sv/leapfrog_kick_drift_energy_defines.svh
// Assertion helpers used by the controller RTL
`ifndef LEAPFROG_KICK_DRIFT_ENERGY_DEFINES_SVH
`define LEAPFROG_KICK_DRIFT_ENERGY_DEFINES_SVH
`define LKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LKD_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);
`endif

### sv/lkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lkd_pkg;
  localparam logic [0:0] REG_POS_STEP = 1'd0;
  localparam logic [0:0] REG_VEL_STEP = 1'd1;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic load;     // capture the input word
    logic step;     // run one sequencer step
    logic [3:0] op; // step index
    logic finish;   // apply energy update
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  localparam int unsigned NUM_OPS = 13;

  // saturate a 66-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return S32_MAX;
    if (x < -66'sd2147483648) return S32_MIN;
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
    return s[63:0];
  endfunction
endpackage
`default_nettype wire

### sv/lkd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lkd_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire lkd_pkg::sts_t sts_i,
  output lkd_pkg::cmd_t cmd_o
);
  import lkd_pkg::*;
  `include "leapfrog_kick_drift_energy_defines.svh"
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;
  logic [1:0] state_q, state_d;
  logic [3:0] op_q, op_d;

  assign in_ready  = (state_q == S_IDLE);
  assign out_valid = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    cmd_o = '0;
    cmd_o.op = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_d = S_RUN;
          op_d = '0;
        end
      end
      S_RUN: begin
        cmd_o.step = 1'b1;
        if (op_q == 4'(NUM_OPS - 1)) begin
          cmd_o.finish = 1'b1;
          state_d = S_OUT;
        end else begin
          op_d = op_q + 4'd1;
        end
      end
      S_OUT: begin
        if (out_ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= '0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
    end
  end

  `LKD_ASSERT_NEXT(a_load_run, in_valid && in_ready, state_q == S_RUN && op_q == 4'd0, "no run")
  `LKD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `LKD_ASSERT(a_excl, !(in_ready && out_valid), "in and out overlap")
  `LKD_ASSERT(a_op_range, op_q < 4'(NUM_OPS), "op out of range")
  // last flag is known while a word is in flight
  `LKD_ASSERT(a_last_known, !$isunknown(sts_i.last) || state_q == S_IDLE, "last unknown")
endmodule
`default_nettype wire

### sv/lkd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module lkd_dp (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire lkd_pkg::cmd_t cmd_i,
  output lkd_pkg::sts_t sts_o,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic cfg_idx_ok_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [31:0] mass_i,
  input  wire logic signed [31:0] p_i [3],
  input  wire logic signed [31:0] v_i [3],
  input  wire logic signed [31:0] a_i [3],
  input  wire logic signed [31:0] phi_i,
  input  wire logic last_i,
  output logic signed [31:0] np_o [3],
  output logic signed [31:0] nv_o [3],
  output logic done_o,
  output logic [62:0] ke_o,
  output logic signed [63:0] pe_o
);
  import lkd_pkg::*;
  localparam logic signed [63:0] HI_LIMIT = 64'sd1099511627776;
  logic signed [31:0] pos_step_q, vel_step_q;
  logic signed [63:0] toff_q, psum_q;
  logic [63:0] ksum_q;
  logic [31:0] mass_q;
  logic signed [31:0] p_q [3], v_q [3], a_q [3], vc_q [3];
  logic signed [31:0] phi_q;
  logic last_q;
  logic [63:0] ssum_q;
  logic signed [63:0] thi_q;
  logic [63:0] mhi_q;

  // op 0..5: centred v, upper then lower half of the time offset per axis
  // op 6..8: kick and square sum, 9..11: drift, 12: energy
  logic [1:0] k;
  logic lo_pass;
  logic signed [32:0] coef;
  logic signed [31:0] mx, base;
  logic signed [64:0] prod;
  logic signed [65:0] hi_part, sum;
  logic signed [31:0] res;
  logic [63:0] sq0;

  always_comb begin
    k = 2'd0;
    lo_pass = 1'b0;
    coef = '0; mx = '0; base = '0;
    unique case (cmd_i.op)
      4'd0, 4'd2, 4'd4: begin
        k = 2'(cmd_i.op >> 1); coef = 33'($signed(toff_q[63:32]));
        mx = a_q[k]; base = v_q[k];
      end
      4'd1, 4'd3, 4'd5: begin
        k = 2'(cmd_i.op >> 1); lo_pass = 1'b1; coef = {1'b0, toff_q[31:0]};
        mx = a_q[k]; base = v_q[k];
      end
      4'd6, 4'd7, 4'd8: begin
        k = 2'(cmd_i.op - 4'd6); coef = 33'(vel_step_q); mx = a_q[k]; base = v_q[k];
      end
      4'd9, 4'd10, 4'd11: begin
        k = 2'(cmd_i.op - 4'd9); coef = 33'(pos_step_q); mx = nv_o[k]; base = p_q[k];
      end
      default: ;
    endcase
    prod = 65'(coef) * 65'(mx);
    // fold in the upper-half product from the previous step
    hi_part = lo_pass ? (66'(thi_q) <<< 2) : 66'sd0;
    sum = 66'(base) + 66'(prod >>> 30) + hi_part;
    if (lo_pass && thi_q > HI_LIMIT) res = S32_MAX;
    else if (lo_pass && thi_q < -HI_LIMIT) res = S32_MIN;
    else res = sat32(sum);
    sq0 = 64'(vc_q[k]) * 64'(vc_q[k]);
  end

  logic [63:0] kt_lo, kterm;
  logic [64:0] kt_sum, ksum_n;
  logic signed [63:0] psum_n;
  always_comb begin
    kt_lo = 64'(mass_q) * 64'(ssum_q[31:0]);
    kt_sum = 65'({mhi_q[47:0], 16'd0}) + 65'(kt_lo[63:16]);
    if (mhi_q[63:48] != 16'd0 || kt_sum[64]) kterm = '1;
    else kterm = kt_sum[63:0];
    ksum_n = 65'(ksum_q) + 65'(kterm);
    if (ksum_n[64]) ksum_n[63:0] = '1;
    psum_n = sadd64(psum_q, 64'($signed({1'b0, mass_q})) * 64'(phi_q));
  end

  assign sts_o.last = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_step_q <= '0; vel_step_q <= '0;
      toff_q <= '0; ksum_q <= '0; psum_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_ok_i) begin
        if (cfg_idx_i == REG_POS_STEP) pos_step_q <= cfg_data_i;
        else vel_step_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          ksum_q <= '0; psum_q <= '0;
          toff_q <= sadd64(toff_q, 64'(pos_step_q) - 64'(vel_step_q));
        end else begin
          ksum_q <= ksum_n[63:0]; psum_q <= psum_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mass_q <= mass_i; phi_q <= phi_i; last_q <= last_i;
      p_q <= p_i; v_q <= v_i; a_q <= a_i;
      ssum_q <= '0;
    end
    if (cmd_i.step) begin
      unique case (cmd_i.op)
        4'd0, 4'd2, 4'd4: thi_q <= 64'(prod);
        4'd1, 4'd3, 4'd5: vc_q[k] <= res;
        4'd6, 4'd7, 4'd8: begin
          nv_o[k] <= res;
          ssum_q <= ssum_q + sq0;
        end
        4'd9, 4'd10, 4'd11: begin
          np_o[k] <= res;
          mhi_q <= 64'(mass_q) * 64'(ssum_q[63:32]);
        end
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      done_o <= last_q;
      ke_o <= last_q ? ksum_n[63:1] : '0;
      pe_o <= last_q ? (psum_n >>> 1) : 64'sd0;
    end
  end
endmodule
`default_nettype wire

### sv/leapfrog_kick_drift_energy.sv
`timescale 1ns / 1ps
// channel  | handshake                | words
// in       | in_valid / in_ready      | particle fields
// out      | out_valid / out_ready    | new pos/vel, energies
// cfg      | cfg_we_i                 | cfg_idx_i, cfg_data_i
// Each particle passes through load, 13 steps of the shared
// 33x32 multiply-add sequencer (two passes per centred axis), then the result register.
// A new particle is taken only after the result word is accepted.
// Reset clears steps, time offset and sums.
`default_nettype none
module leapfrog_kick_drift_energy (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [31:0] mass_i,
  input  wire logic signed [31:0] pos_x_i, pos_y_i, pos_z_i,
  input  wire logic signed [31:0] vel_x_i, vel_y_i, vel_z_i,
  input  wire logic signed [31:0] acc_x_i, acc_y_i, acc_z_i,
  input  wire logic signed [31:0] potential_i,
  input  wire logic last_particle_i,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [31:0] new_pos_x_o, new_pos_y_o, new_pos_z_o,
  output logic signed [31:0] new_vel_x_o, new_vel_y_o, new_vel_z_o,
  output logic pass_done_o,
  output logic [62:0] kinetic_energy_o,
  output logic signed [63:0] potential_energy_o
);
  import lkd_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] p [3], v [3], a [3], np [3], nv [3];
  assign p = '{pos_x_i, pos_y_i, pos_z_i};
  assign v = '{vel_x_i, vel_y_i, vel_z_i};
  assign a = '{acc_x_i, acc_y_i, acc_z_i};
  assign new_pos_x_o = np[0]; assign new_pos_y_o = np[1]; assign new_pos_z_o = np[2];
  assign new_vel_x_o = nv[0]; assign new_vel_y_o = nv[1]; assign new_vel_z_o = nv[2];

  lkd_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
                   .sts_i(sts), .cmd_o(cmd));
  lkd_dp u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i,
               .cfg_idx_i(cfg_idx_i[0]), .cfg_idx_ok_i(1'b1), .cfg_data_i,
               .mass_i, .p_i(p), .v_i(v), .a_i(a), .phi_i(potential_i),
               .last_i(last_particle_i), .np_o(np), .nv_o(nv), .done_o(pass_done_o),
               .ke_o(kinetic_energy_o), .pe_o(potential_energy_o));
endmodule
`default_nettype wire
